### hdl/tqpe_pkg.sv
// Shared types, codes and constants of the ticket queue with priority extraction.
package tqpe_pkg;

  localparam int unsigned DepthDefault = 16;

  localparam int unsigned IdW      = 16;
  localparam int unsigned PrioW    = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CountOutW = 5;

  localparam int unsigned InDataW  = 64;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 64;
  localparam int unsigned OutUserW = 3;

  typedef enum logic [2:0] {
    OP_ENQ    = 3'd0,
    OP_DEQ    = 3'd1,
    OP_RMMIN  = 3'd2,
    OP_FIND   = 3'd3,
    OP_OLDEST = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    RC_OK    = 2'd0,
    RC_EMPTY = 2'd1,
    RC_FULL  = 2'd2
  } rc_e;

  // One stored ticket, packed in the same order as the word fields.
  typedef struct packed {
    logic [TimeW-1:0] created;
    logic             open;
    logic [PrioW-1:0] prio;
    logic [IdW-1:0]   id;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

### hdl/ticket_queue_with_priority_extract_top.sv
// Top level of the ticket queue: entry memory, scan and shift sequencer, output register.
//
//  Channel  | Dir | Signals                    | Contents (lowest bit first)
//  ---------+-----+----------------------------+-----------------------------------------
//  s_axis   | in  | tvalid tready tdata tuser  | tuser: operation; tdata: ticket_id,
//           |     |                            | priority_req, is_open, created_time
//  m_axis   | out | tvalid tready tdata tuser  | tuser: found, result_code; tdata: out_id,
//           |     |                            | out_priority, out_open, out_created, count
//
// Every operation returns exactly one word. Enqueue and unused operation codes go from
// idle straight to the finish state. Find and oldest-open read the entries one per cycle
// through the single memory read port. Dequeue reads only the head; dequeue and
// remove-lowest then close the gap by moving each later entry down one place, with a read
// and then a write per moved entry, on top of the scan.
// Reset clears the entry count and the sequencer; the entry memory itself is not cleared.
// A finished word waits in the output register, so a stall on m_axis only holds the next
// operation in its final cycle; the input side is ready whenever the sequencer is idle.
module ticket_queue_with_priority_extract_top #(
  parameter int unsigned DEPTH = tqpe_pkg::DepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] ticket_id, [23:16] priority_req, [24] is_open, [56:25] created_time, rest zero
  input  logic [tqpe_pkg::InDataW-1:0]   s_axis_tdata,
  // [2:0] operation
  input  logic [tqpe_pkg::InUserW-1:0]   s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] out_id, [23:16] out_priority, [24] out_open, [56:25] out_created,
  // [61:57] entry_count, rest zero
  output logic [tqpe_pkg::OutDataW-1:0]  m_axis_tdata,
  // [0] found, [2:1] result_code
  output logic [tqpe_pkg::OutUserW-1:0]  m_axis_tuser
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_SH_RD  = 5'b00100,
    ST_SH_WR  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Entry memory: one write port, one registered read port.
  tqpe_pkg::entry_t mem_q [DEPTH];
  tqpe_pkg::entry_t rdata_q;
  logic [IW-1:0]    rd_addr;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  tqpe_pkg::entry_t wr_data;

  logic [CW-1:0]    count_q, count_d;
  tqpe_pkg::op_e    op_q, op_d;
  logic [tqpe_pkg::IdW-1:0] key_q, key_d;
  tqpe_pkg::rc_e    rc_q, rc_d;

  logic [CW-1:0]    scan_idx_q, scan_idx_d;
  logic [CW-1:0]    scan_end_q, scan_end_d;
  logic             pend_q, pend_d;
  logic [IW-1:0]    pend_idx_q, pend_idx_d;

  logic             have_q, have_d;
  tqpe_pkg::entry_t best_q, best_d;
  logic [IW-1:0]    best_idx_q, best_idx_d;
  logic [IW-1:0]    sh_idx_q, sh_idx_d;
  logic [CW-1:0]    sh_next;

  logic                          m_valid_q, m_valid_d;
  logic [tqpe_pkg::OutDataW-1:0] m_data_q, m_data_d;
  logic [tqpe_pkg::OutUserW-1:0] m_user_q, m_user_d;

  tqpe_pkg::entry_t in_entry;
  logic             in_accept;
  logic             take;
  logic             full;
  logic [CW+4:0]    count_ext;

  assign in_entry  = tqpe_pkg::entry_t'(s_axis_tdata[tqpe_pkg::EntryW-1:0]);
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign full      = (count_q == CW'(DEPTH));
  assign sh_next   = CW'(sh_idx_q) + CW'(1);
  assign count_ext = {5'd0, count_q};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // The shared compare unit: decides whether the entry just read becomes the candidate.
  always_comb begin
    case (op_q)
      tqpe_pkg::OP_DEQ:    take = !have_q;
      tqpe_pkg::OP_RMMIN:  take = !have_q || (rdata_q.prio < best_q.prio);
      tqpe_pkg::OP_FIND:   take = !have_q && (rdata_q.id == key_q);
      tqpe_pkg::OP_OLDEST: take = rdata_q.open &&
                                  (!have_q || (rdata_q.created < best_q.created));
      default:             take = 1'b0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    op_d       = op_q;
    key_d      = key_q;
    rc_d       = rc_q;
    scan_idx_d = scan_idx_q;
    scan_end_d = scan_end_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    have_d     = have_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    sh_idx_d   = sh_idx_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;
    rd_addr    = scan_idx_q[IW-1:0];
    wr_en      = 1'b0;
    wr_addr    = sh_idx_q;
    wr_data    = rdata_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          op_d       = tqpe_pkg::op_e'(s_axis_tuser[2:0]);
          key_d      = in_entry.id;
          have_d     = 1'b0;
          best_d     = '0;
          scan_idx_d = '0;
          rc_d       = tqpe_pkg::RC_OK;
          case (tqpe_pkg::op_e'(s_axis_tuser[2:0]))
            tqpe_pkg::OP_ENQ: begin
              state_d = ST_FINISH;
              if (full) begin
                rc_d = tqpe_pkg::RC_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = count_q[IW-1:0];
                wr_data = in_entry;
                count_d = count_q + CW'(1);
              end
            end
            tqpe_pkg::OP_DEQ: begin
              // Only the head matters for a dequeue.
              scan_end_d = (count_q != '0) ? CW'(1) : '0;
              state_d    = ST_SCAN;
            end
            tqpe_pkg::OP_RMMIN, tqpe_pkg::OP_FIND, tqpe_pkg::OP_OLDEST: begin
              scan_end_d = count_q;
              state_d    = ST_SCAN;
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (scan_idx_q < scan_end_q) begin
          rd_addr    = scan_idx_q[IW-1:0];
          pend_d     = 1'b1;
          pend_idx_d = scan_idx_q[IW-1:0];
          scan_idx_d = scan_idx_q + CW'(1);
        end
        if (pend_q && take) begin
          have_d     = 1'b1;
          best_d     = rdata_q;
          best_idx_d = pend_idx_q;
        end
        if ((scan_idx_q == scan_end_q) && !pend_q) begin
          if (!have_q) begin
            rc_d    = tqpe_pkg::RC_EMPTY;
            state_d = ST_FINISH;
          end else if ((op_q == tqpe_pkg::OP_DEQ) || (op_q == tqpe_pkg::OP_RMMIN)) begin
            sh_idx_d = best_idx_q;
            state_d  = ST_SH_RD;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end

      ST_SH_RD: begin
        rd_addr = sh_next[IW-1:0];
        if (sh_next < count_q) begin
          state_d = ST_SH_WR;
        end else begin
          count_d = count_q - CW'(1);
          state_d = ST_FINISH;
        end
      end

      ST_SH_WR: begin
        wr_en    = 1'b1;
        wr_addr  = sh_idx_q;
        wr_data  = rdata_q;
        sh_idx_d = sh_next[IW-1:0];
        state_d  = ST_SH_RD;
      end

      ST_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {{(tqpe_pkg::OutDataW - tqpe_pkg::EntryW - 5){1'b0}},
                       count_ext[4:0], best_q};
          m_user_d  = {rc_q, have_q};
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      pend_q    <= 1'b0;
      have_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pend_q    <= pend_d;
      have_q    <= have_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    rc_q       <= rc_d;
    scan_idx_q <= scan_idx_d;
    scan_end_q <= scan_end_d;
    pend_idx_q <= pend_idx_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    sh_idx_q   <= sh_idx_d;
    m_data_q   <= m_data_d;
    m_user_q   <= m_user_d;
  end

endmodule

### hdl/tqpe_checker.sv
// Port-level checker for the ticket queue and its bind to the top level.
module tqpe_checker #(
  parameter int unsigned DEPTH = tqpe_pkg::DepthDefault
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [tqpe_pkg::InDataW-1:0]  s_axis_tdata,
  input logic [tqpe_pkg::InUserW-1:0]  s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tqpe_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [tqpe_pkg::OutUserW-1:0] m_axis_tuser
);

  // After an accepted word the sequencer leaves idle, so the input side drops ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input side ready right after an accepted word");

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result word changed while stalled");

  // No entry reported means all entry fields are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[56:0] == '0))
    else $error("entry fields set without an entry found");

  // A full report never carries an entry and shows a full store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser[2:1] == tqpe_pkg::RC_FULL)) |->
      (!m_axis_tuser[0] && (m_axis_tdata[61:57] == 5'(DEPTH))))
    else $error("store-full result with wrong count or an entry");

  // The count never exceeds the depth where the count field can show it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((DEPTH > 31) || (32'(m_axis_tdata[61:57]) <= DEPTH)))
    else $error("entry count above depth");

endmodule

bind ticket_queue_with_priority_extract_top tqpe_checker #(
  .DEPTH(DEPTH)
) u_tqpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### test/ticket_queue_with_priority_extract_top_tb.sv
// Self-checking testbench for the ticket queue with priority extraction.
module ticket_queue_with_priority_extract_top_tb;

  localparam int unsigned Depth = tqpe_pkg::DepthDefault;
  // Operation codes 5 to 7 have no meaning; the queue must leave its contents alone.
  localparam logic [2:0] OpSpareFirst = 3'd5;
  localparam logic [2:0] OpSpareLast  = 3'd7;
  // Cycles without any accepted word before the run is declared hung. The slowest
  // operation is remove-lowest on a full queue.
  localparam int unsigned HangLimit = 2000;
  // Cycles to keep watching for stray reply words once nothing is outstanding.
  localparam int unsigned SettleCycles = 64;

  // One reply word as the queue should produce it.
  typedef struct {
    logic             found;
    tqpe_pkg::entry_t ent;
    logic [4:0]       count;
    tqpe_pkg::rc_e    rc;
  } reply_t;

  // Mirror of the ticket store. It keeps the tickets in arrival order, works out the reply
  // word of each accepted request, and checks reply words in order against those results.
  class ticket_queue_mirror;
    tqpe_pkg::entry_t held[$];
    reply_t           owed[$];
    int unsigned      error_count;

    function new();
      error_count = 0;
    endfunction

    function void note_request(logic [2:0] op, tqpe_pkg::entry_t req);
      reply_t r;
      int     best;
      best    = -1;
      r.found = 1'b0;
      r.ent   = '0;
      r.rc    = tqpe_pkg::RC_OK;
      case (op)
        tqpe_pkg::OP_ENQ: begin
          if (held.size() >= Depth) r.rc = tqpe_pkg::RC_FULL;
          else held.push_back(req);
        end
        tqpe_pkg::OP_DEQ: begin
          if (held.size() == 0) r.rc = tqpe_pkg::RC_EMPTY;
          else best = 0;
        end
        tqpe_pkg::OP_RMMIN: begin
          // Strict less-than keeps the earliest of equal priorities.
          if (held.size() == 0) r.rc = tqpe_pkg::RC_EMPTY;
          else begin
            best = 0;
            for (int k = 1; k < held.size(); k++)
              if (held[k].prio < held[best].prio) best = k;
          end
        end
        tqpe_pkg::OP_FIND: begin
          for (int k = 0; k < held.size(); k++)
            if (best < 0 && held[k].id == req.id) best = k;
          if (best < 0) r.rc = tqpe_pkg::RC_EMPTY;
        end
        tqpe_pkg::OP_OLDEST: begin
          for (int k = 0; k < held.size(); k++)
            if (held[k].open && (best < 0 || held[k].created < held[best].created)) best = k;
          if (best < 0) r.rc = tqpe_pkg::RC_EMPTY;
        end
        default: begin
        end
      endcase
      if (best >= 0) begin
        r.found = 1'b1;
        r.ent   = held[best];
        // Only dequeue and remove-lowest take the entry out, and the later entries close up behind it.
        if (op == tqpe_pkg::OP_DEQ || op == tqpe_pkg::OP_RMMIN) held.delete(best);
      end
      r.count = 5'(held.size());
      owed.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        error_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_reply(logic [tqpe_pkg::OutDataW-1:0] data,
                              logic [tqpe_pkg::OutUserW-1:0] user);
      reply_t want;
      if (owed.size() == 0) begin
        error_count++;
        $display("%0t: reply word with nothing outstanding, expected none, actual data %h user %h",
                 $time, data, user);
        return;
      end
      want = owed.pop_front();
      compare_field("found", 32'(want.found), 32'(user[0]));
      compare_field("result_code", 32'(want.rc), 32'(user[2:1]));
      compare_field("out_id", 32'(want.ent.id), 32'(data[15:0]));
      compare_field("out_priority", 32'(want.ent.prio), 32'(data[23:16]));
      compare_field("out_open", 32'(want.ent.open), 32'(data[24]));
      compare_field("out_created", want.ent.created, data[56:25]);
      compare_field("entry_count", 32'(want.count), 32'(data[61:57]));
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [tqpe_pkg::InDataW-1:0]  s_axis_tdata;
  logic [tqpe_pkg::InUserW-1:0]  s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [tqpe_pkg::OutDataW-1:0] m_axis_tdata;
  logic [tqpe_pkg::OutUserW-1:0] m_axis_tuser;

  ticket_queue_with_priority_extract_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  ticket_queue_mirror sb = new();

  // Chance in percent that the sender opens a gap before a word, and that the receiver
  // starts a stall burst; both are changed from phase to phase and are zero at the end.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned hang_cycles = 0;

  always #1 clk_i = ~clk_i;

  // Receiver: ready drops in stall bursts, each one started with chance stall_pct.
  initial begin
    int unsigned hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold == 0 && $urandom_range(0, 99) < stall_pct) hold = $urandom_range(1, 10);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Reply checking and the hang watchdog, both on the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tdata, m_axis_tuser);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HangLimit) begin
      $display("%0t: no word accepted for %0d cycles", $time, HangLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  // Offers one request word, possibly after a gap, and notes it once it is taken.
  task automatic send_word(logic [2:0] op, logic [15:0] id, logic [7:0] prio, logic open,
                           logic [31:0] ctime);
    tqpe_pkg::entry_t req;
    req.id      = id;
    req.prio    = prio;
    req.open    = open;
    req.created = ctime;
    @(negedge clk_i);
    if ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'b0, ctime, open, prio, id};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(op, req);
  endtask

  // Holds the sender back until every outstanding reply word has come in.
  task automatic wait_for_replies();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
  endtask

  // Short directed run: empty queue, filling to the brim with extreme and tied values,
  // the full case, each search, and the spare codes.
  task automatic run_directed();
    logic [15:0] id;
    logic [7:0]  prio;
    logic [31:0] ctime;
    send_word(tqpe_pkg::OP_DEQ, 16'hFFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    send_word(tqpe_pkg::OP_RMMIN, 16'h0000, 8'h00, 1'b0, 32'h0);
    for (int k = 0; k < Depth; k++) begin
      // Repeated ids, several entries tied at priority zero, and open entries tied in time.
      id    = 16'(k % 5);
      prio  = (k % 4 == 1) ? 8'h00 : 8'(8'h80 + k);
      ctime = (k >= 8) ? 32'd5 : 32'hFFFF_0000 + 32'(k);
      if (k == 0) send_word(tqpe_pkg::OP_ENQ, 16'hFFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF);
      else if (k == 1) send_word(tqpe_pkg::OP_ENQ, 16'h0000, 8'h00, 1'b0, 32'h0);
      else send_word(tqpe_pkg::OP_ENQ, id, prio, 1'(k), ctime);
    end
    send_word(tqpe_pkg::OP_ENQ, 16'hABCD, 8'h01, 1'b1, 32'h1);
    send_word(tqpe_pkg::OP_RMMIN, 16'h0, 8'h0, 1'b0, 32'h0);
    send_word(tqpe_pkg::OP_FIND, 16'h0003, 8'h0, 1'b0, 32'h0);
    send_word(tqpe_pkg::OP_FIND, 16'hBEEF, 8'h0, 1'b0, 32'h0);
    send_word(tqpe_pkg::OP_OLDEST, 16'h0, 8'h0, 1'b0, 32'h0);
    send_word(tqpe_pkg::OP_DEQ, 16'h0, 8'h0, 1'b0, 32'h0);
    for (int s = OpSpareFirst; s <= OpSpareLast; s++)
      send_word(3'(s), 16'hFFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF);
  endtask

  // Random run in phases that lean toward filling, draining or a mix, so the entry count
  // sweeps between empty and full. Spare codes are sent but not counted.
  task automatic run_random(int unsigned target);
    int unsigned done;
    int unsigned phase_left;
    int unsigned enq_pct;
    int unsigned r;
    logic [2:0]  op;
    logic [15:0] id;
    logic [7:0]  prio;
    logic [31:0] ctime;
    done       = 0;
    phase_left = 0;
    enq_pct    = 40;
    while (done < target) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0:       enq_pct = 70;
          1:       enq_pct = 15;
          default: enq_pct = 40;
        endcase
        gap_pct   = $urandom_range(0, 1) ? $urandom_range(10, 40) : 0;
        stall_pct = $urandom_range(0, 1) ? $urandom_range(10, 40) : 0;
        if ($urandom_range(0, 3) == 0) wait_for_replies();
      end
      phase_left--;
      // The closing stretch runs without any idling on either side.
      if (target - done < 100) begin
        gap_pct   = 0;
        stall_pct = 0;
      end

      r = $urandom_range(0, 99);
      if (r < enq_pct) op = tqpe_pkg::OP_ENQ;
      else begin
        r = $urandom_range(0, 99);
        if (r < 25) op = tqpe_pkg::OP_DEQ;
        else if (r < 50) op = tqpe_pkg::OP_RMMIN;
        else if (r < 72) op = tqpe_pkg::OP_FIND;
        else if (r < 95) op = tqpe_pkg::OP_OLDEST;
        else op = 3'($urandom_range(OpSpareFirst, OpSpareLast));
      end

      if (op == tqpe_pkg::OP_FIND && sb.held.size() != 0 && $urandom_range(0, 1))
        id = sb.held[$urandom_range(0, sb.held.size() - 1)].id;
      else if ($urandom_range(0, 2) == 0) id = 16'($urandom_range(0, 7));
      else id = 16'($urandom);
      case ($urandom_range(0, 3))
        0:       prio = 8'($urandom_range(0, 3));
        1:       prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: prio = 8'($urandom);
      endcase
      ctime = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 7)) : 32'($urandom);

      if (op < OpSpareFirst) done++;
      send_word(op, id, prio, 1'($urandom), ctime);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    gap_pct   = 20;
    stall_pct = 20;
    run_directed();
    wait_for_replies();
    run_random(850);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (sb.owed.size() != 0)
      $display("%0t: %0d reply words never arrived", $time, sb.owed.size());
    if (sb.error_count == 0 && sb.owed.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/tqpe_pkg.sv
hdl/ticket_queue_with_priority_extract_top.sv
hdl/tqpe_checker.sv
test/ticket_queue_with_priority_extract_top_tb.sv
